@@ design/sst_pkg.sv @@
// shared types and constants for the small set table
package sst_pkg;

   localparam int CAPACITY_DEFAULT = 8;

   localparam logic [1:0] OP_FIND   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [2:0] position;
      logic [3:0] entry_count;
      logic       full_reject;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic scan_next;
      logic mark_hit;
      logic append;
      logic reject;
      logic shift_first;
      logic shift_step;
      logic drop;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       count_zero;
      logic       match;
      logic       scan_last;
      logic       hit;
      logic       room;
      logic       shift_needed;
      logic       shift_more;
   } status_type;

endpackage

@@ design/small_set_table.sv @@
// top level of the small set table
//
// A bounded set of distinct 32-bit values kept packed in insertion order.
// A request transfers when start is high and busy is low; req_data holds
// the operation (find, insert if absent, delete if present) and the value.
// Exactly one result follows, shown on rsp_data for a single cycle while
// rsp_strobe is high; the receiver must take it then, it cannot stall.
// The scan stops at the first match or after the last entry; an empty
// set is not scanned. The scan reads one entry per cycle from the
// storage's read port, and a delete moves each later entry one place
// down, one entry per cycle, reading and writing the storage in the same
// cycle. A new request may transfer in the cycle after the strobe.
// Reset empties the set at once; stored values are only read below the
// entry count, so the storage needs no clearing.
module small_set_table #(
   parameter int CAPACITY = sst_pkg::CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sst_pkg::req_type req_data,
   output logic             rsp_strobe,
   output sst_pkg::rsp_type rsp_data
);
   import sst_pkg::*;

   cmd_type    cmd;
   status_type status;

   sst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   sst_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

@@ design/sst_datapath.sv @@
// set storage, scan index, count and result registers
module sst_datapath #(
   parameter int CAPACITY = sst_pkg::CAPACITY_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  sst_pkg::req_type    req_data,
   input  sst_pkg::cmd_type    cmd,
   output sst_pkg::status_type status,
   output sst_pkg::rsp_type    rsp_data
);
   import sst_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic signed [31:0] mem [CAPACITY];

   logic [1:0]         op_ff;
   logic signed [31:0] value_ff;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [2:0]         pos_ff, pos_in;
   logic               hit_ff, hit_in;
   logic               reject_ff, reject_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic signed [31:0] rd_data_ff;

   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic signed [31:0] wr_data;

   logic [CNT_W:0]     idx_plus1;
   logic [CNT_W:0]     idx_plus2;

   assign idx_plus1 = (CNT_W + 1)'(idx_ff) + (CNT_W + 1)'(1);
   assign idx_plus2 = (CNT_W + 1)'(idx_ff) + (CNT_W + 1)'(2);

   // memory port control
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = rd_data_ff;
      if (cmd.load) begin
         rd_en   = (count_ff != '0);
         rd_addr = '0;
      end
      if (cmd.scan_next || cmd.shift_first) begin
         rd_en   = 1'b1;
         rd_addr = idx_plus1[IDX_W-1:0];
      end
      if (cmd.shift_step) begin
         rd_en   = idx_plus2 < (CNT_W + 1)'(count_ff);
         rd_addr = idx_plus2[IDX_W-1:0];
         wr_en   = 1'b1;
         wr_addr = idx_ff;
         wr_data = rd_data_ff;
      end
      if (cmd.append) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[IDX_W-1:0];
         wr_data = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // control registers
   always_comb begin
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      hit_in    = hit_ff;
      reject_in = reject_ff;
      count_in  = count_ff;
      if (cmd.load) begin
         idx_in    = '0;
         pos_in    = '0;
         hit_in    = 1'b0;
         reject_in = 1'b0;
      end
      if (cmd.scan_next || cmd.shift_step) begin
         idx_in = idx_plus1[IDX_W-1:0];
      end
      if (cmd.mark_hit) begin
         hit_in = 1'b1;
         pos_in = 3'(idx_ff);
      end
      if (cmd.append) begin
         pos_in   = 3'(count_ff);
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.reject) begin
         reject_in = 1'b1;
      end
      if (cmd.drop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         hit_ff    <= 1'b0;
         reject_ff <= 1'b0;
         pos_ff    <= '0;
         idx_ff    <= '0;
      end else begin
         count_ff  <= count_in;
         hit_ff    <= hit_in;
         reject_ff <= reject_in;
         pos_ff    <= pos_in;
         idx_ff    <= idx_in;
      end
   end

   // request payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_data.operation;
         value_ff <= req_data.value;
      end
   end

   always_comb begin
      status.op           = op_ff;
      status.count_zero   = (count_ff == '0);
      status.match        = (rd_data_ff == value_ff);
      status.scan_last    = (idx_plus1 == (CNT_W + 1)'(count_ff));
      status.hit          = hit_ff;
      status.room         = (count_ff < CNT_W'(CAPACITY));
      status.shift_needed = (idx_plus1 < (CNT_W + 1)'(count_ff));
      status.shift_more   = (idx_plus2 < (CNT_W + 1)'(count_ff));
   end

   assign rsp_data.found       = hit_ff;
   assign rsp_data.position    = pos_ff;
   assign rsp_data.entry_count = 4'(count_ff);
   assign rsp_data.full_reject = reject_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> count_ff < CNT_W'(CAPACITY))
      else $error("append into a full set");

   a_drop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.drop |-> count_ff != '0)
      else $error("delete from an empty set");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_step |-> idx_plus1 < (CNT_W + 1)'(count_ff))
      else $error("shift past the last entry");

endmodule

@@ design/sst_ctrl.sv @@
// request sequencer for the small set table
module sst_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  sst_pkg::status_type status,
   output logic                busy,
   output logic                rsp_strobe,
   output sst_pkg::cmd_type    cmd
);
   import sst_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DECIDE = 5'b00100,
      ST_SHIFT  = 5'b01000,
      ST_RESP   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = status.count_zero ? ST_DECIDE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.match) begin
               cmd.mark_hit = 1'b1;
               state_in     = ST_DECIDE;
            end else if (status.scan_last) begin
               state_in = ST_DECIDE;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_DECIDE: begin
            state_in = ST_RESP;
            case (status.op)
               OP_INSERT: begin
                  if (!status.hit) begin
                     if (status.room) begin
                        cmd.append = 1'b1;
                     end else begin
                        cmd.reject = 1'b1;
                     end
                  end
               end
               OP_DELETE: begin
                  if (status.hit) begin
                     if (status.shift_needed) begin
                        cmd.shift_first = 1'b1;
                        state_in        = ST_SHIFT;
                     end else begin
                        cmd.drop = 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (!status.shift_more) begin
               cmd.drop = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_RESP);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("transfer accepted but sequencer idle");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_shift_needs_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_first |-> status.hit && status.op == OP_DELETE)
      else $error("shift without a delete hit");

endmodule
